// File: hw/rtl/plcl_pkg.sv
// ----------------------------------------------------------------------------
// plcl_pkg
// Shared constants and types of the piecewise-linear color lookup.
// ----------------------------------------------------------------------------
package plcl_pkg;

  localparam int MAX_POINTS   = 7;
  localparam int VALUE_BITS   = 16;
  localparam int CHANNEL_BITS = 8;
  localparam int NUM_CHAN     = 4;
  localparam int IDX_BITS     = $clog2(MAX_POINTS);
  localparam int REG_BITS     = 48;
  localparam int POS_LSB      = 32;

  localparam logic [2:0] REG_POINT_COUNT = 3'd0;

  typedef logic [VALUE_BITS-1:0]                     value_t;
  typedef logic [CHANNEL_BITS-1:0]                   chan_t;
  typedef logic [NUM_CHAN-1:0][CHANNEL_BITS-1:0]     color_t;
  typedef logic [MAX_POINTS-1:0][VALUE_BITS-1:0]     pos_array_t;
  typedef logic [MAX_POINTS-1:0][NUM_CHAN-1:0][CHANNEL_BITS-1:0] color_array_t;

  typedef struct packed {
    logic                                     direct;
    logic [VALUE_BITS-1:0]                    d;
    logic [NUM_CHAN-1:0][VALUE_BITS-1:0]      rem;
    logic [NUM_CHAN-1:0][CHANNEL_BITS-1:0]    low;
    logic [NUM_CHAN-1:0][CHANNEL_BITS-1:0]    quo;
  } cell_t;

endpackage

// File: hw/rtl/plcl_select.sv
// ----------------------------------------------------------------------------
// plcl_select
// Segment search and weighted sum, two registered stages feeding the divider.
// ----------------------------------------------------------------------------
module plcl_select (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  plcl_pkg::value_t      sample_value,
  input  logic [2:0]            point_count,
  input  plcl_pkg::pos_array_t  pos,
  input  plcl_pkg::color_array_t color,
  output logic                  out_valid,
  input  logic                  out_ready,
  output plcl_pkg::cell_t       out_beat
);

  localparam int VB = plcl_pkg::VALUE_BITS;
  localparam int CB = plcl_pkg::CHANNEL_BITS;
  localparam int NC = plcl_pkg::NUM_CHAN;
  localparam int IW = plcl_pkg::IDX_BITS;

  logic [2:0]          n;
  logic [IW-1:0]       last;
  logic [IW-1:0]       hi;
  logic [IW-1:0]       lo;
  logic                hit;
  logic                direct;
  plcl_pkg::color_t    dcolor;

  logic                a_valid;
  logic                a_en;
  logic                a_direct;
  plcl_pkg::color_t    a_color;
  plcl_pkg::value_t    a_d;
  plcl_pkg::value_t    a_t;
  plcl_pkg::color_t    a_clo;
  plcl_pkg::color_t    a_chi;

  logic                b_en;
  logic [NC-1:0][VB+CB-1:0] num;

  always_comb begin
    n = (point_count > 3'(plcl_pkg::MAX_POINTS)) ? 3'(plcl_pkg::MAX_POINTS) : point_count;
    last = (n == 3'd0) ? '0 : IW'(n - 3'd1);
    hit = 1'b0;
    hi = last;
    for (int c = 1; c < plcl_pkg::MAX_POINTS; c++) begin
      if (!hit && c <= int'(last) && pos[c] >= sample_value) begin
        hi = IW'(c);
        hit = 1'b1;
      end
    end
    lo = (hi == '0) ? '0 : hi - IW'(1);
    direct = 1'b1;
    if (n == 3'd0) begin
      dcolor = '1;
    end else if (n == 3'd1 || sample_value <= pos[0]) begin
      dcolor = color[0];
    end else if (sample_value >= pos[last]) begin
      dcolor = color[last];
    end else if (pos[hi] == sample_value) begin
      dcolor = color[hi];
    end else begin
      dcolor = '0;
      direct = 1'b0;
    end
  end

  assign b_en     = !out_valid || out_ready;
  assign a_en     = !a_valid || b_en;
  assign in_ready = a_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_en) begin
      a_valid <= in_valid;
    end
    if (a_en && in_valid) begin
      a_direct <= direct;
      a_color  <= dcolor;
      a_d      <= pos[hi] - pos[lo];
      a_t      <= sample_value - pos[lo];
      a_clo    <= color[lo];
      a_chi    <= color[hi];
    end
  end

  always_comb begin
    for (int c = 0; c < NC; c++) begin
      num[c] = (VB+CB)'(a_clo[c]) * (VB+CB)'(a_d - a_t)
             + (VB+CB)'(a_chi[c]) * (VB+CB)'(a_t)
             + (VB+CB)'(a_d >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_en) begin
      out_valid <= a_valid;
    end
    if (b_en && a_valid) begin
      out_beat.direct <= a_direct;
      out_beat.d      <= a_d;
      for (int c = 0; c < NC; c++) begin
        out_beat.rem[c] <= num[c][VB+CB-1:CB];
        out_beat.low[c] <= num[c][CB-1:0];
      end
      out_beat.quo <= a_direct ? a_color : '0;
    end
  end

endmodule

// File: hw/rtl/plcl_div_cell.sv
// ----------------------------------------------------------------------------
// plcl_div_cell
// One restoring division step on all four channels, one quotient bit each; direct beats pass unchanged.
// ----------------------------------------------------------------------------
module plcl_div_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  plcl_pkg::cell_t in_beat,
  output logic            out_valid,
  input  logic            out_ready,
  output plcl_pkg::cell_t out_beat
);

  localparam int VB = plcl_pkg::VALUE_BITS;
  localparam int CB = plcl_pkg::CHANNEL_BITS;
  localparam int NC = plcl_pkg::NUM_CHAN;

  logic            en;
  logic [VB:0]     r2;
  plcl_pkg::cell_t beat_next;

  always_comb begin
    beat_next = in_beat;
    r2 = '0;
    if (!in_beat.direct) begin
      for (int c = 0; c < NC; c++) begin
        r2 = {in_beat.rem[c], in_beat.low[c][CB-1]};
        beat_next.low[c] = in_beat.low[c] << 1;
        if (r2 >= {1'b0, in_beat.d}) begin
          beat_next.rem[c] = VB'(r2 - {1'b0, in_beat.d});
          beat_next.quo[c] = {in_beat.quo[c][CB-2:0], 1'b1};
        end else begin
          beat_next.rem[c] = r2[VB-1:0];
          beat_next.quo[c] = {in_beat.quo[c][CB-2:0], 1'b0};
        end
      end
    end
  end

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en && in_valid) begin
      out_beat <= beat_next;
    end
  end

endmodule

// File: hw/rtl/piecewise_linear_color_lookup_core.sv
// ----------------------------------------------------------------------------
// piecewise_linear_color_lookup_core
// Maps a sample value to an RGBA color between up to seven control points.
// ----------------------------------------------------------------------------
// Usage:
//   cfg channel writes register cfg_index with cfg_data: index 0 is the
//   point count, 1 to 7 the packed control points; cfg_ready is always high.
//   Write it only while no beat is in flight.
//   in channel carries sample_value; out channel returns red, green, blue,
//   alpha for each input beat, in order.
//   Beats pass through the segment search and weighted sum stages, eight
//   divider cells (one quotient bit each) and an output register.
//   Throughput is one beat per cycle while out_ready is high; every stage
//   holds its beat while the next one is full, so a stalled receiver backs
//   up the chain and bubbles close up.
//   Reset clears the configuration registers to 0 and empties the pipeline.
// ----------------------------------------------------------------------------
module piecewise_linear_color_lookup_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] sample_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  output logic [7:0]  alpha
);

  localparam int VB = plcl_pkg::VALUE_BITS;
  localparam int CB = plcl_pkg::CHANNEL_BITS;
  localparam int NC = plcl_pkg::NUM_CHAN;
  localparam int MP = plcl_pkg::MAX_POINTS;

  logic [2:0]             point_count;
  plcl_pkg::pos_array_t   pos;
  plcl_pkg::color_array_t color;

  logic [CB:0]                  valid;
  logic [CB:0]                  ready;
  plcl_pkg::cell_t [CB:0]       beat;
  logic                         last_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= '0;
      pos         <= '0;
      color       <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == plcl_pkg::REG_POINT_COUNT) begin
        point_count <= cfg_data[2:0];
      end else begin
        for (int k = 0; k < MP; k++) begin
          if (int'(cfg_index) == k + 1) begin
            pos[k] <= cfg_data[plcl_pkg::POS_LSB +: VB];
            for (int c = 0; c < NC; c++) begin
              color[k][c] <= cfg_data[24 - 8*c +: CB];
            end
          end
        end
      end
    end
  end

  plcl_select u_select (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .sample_value (VB'(sample_value)),
    .point_count  (point_count),
    .pos          (pos),
    .color        (color),
    .out_valid    (valid[0]),
    .out_ready    (ready[0]),
    .out_beat     (beat[0])
  );

  for (genvar g = 0; g < CB; g++) begin : g_cell
    plcl_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (valid[g]),
      .in_ready  (ready[g]),
      .in_beat   (beat[g]),
      .out_valid (valid[g+1]),
      .out_ready (ready[g+1]),
      .out_beat  (beat[g+1])
    );
  end

  assign last_ready = !out_valid || out_ready;
  assign ready[CB]  = last_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (last_ready) begin
      out_valid <= valid[CB];
    end
    if (last_ready && valid[CB]) begin
      red   <= 8'(beat[CB].quo[0]);
      green <= 8'(beat[CB].quo[1]);
      blue  <= 8'(beat[CB].quo[2]);
      alpha <= 8'(beat[CB].quo[3]);
    end
  end

endmodule
